// File: rtl/heq_pkg.sv
// ----------------------------------------------------------------------------
// heq_pkg
// shared widths, codes, item types and helpers of the histogram equalizer
// ----------------------------------------------------------------------------
package heq_pkg;

  localparam int PIX_W       = 8;
  localparam int HIST_DEPTH  = 256;
  localparam int CFG_W       = 13;
  localparam int MAX_SIDE    = 4096;
  localparam int W_RESET     = 640;
  localparam int H_RESET     = 480;

  // frame size and counts reach MAX_SIDE*MAX_SIDE, one bit more than 24
  localparam int CNT_W       = 25;
  localparam int BIN_W       = 25;
  // 510*cdf + N and 2N << 8 both stay below 2**34
  localparam int NUM_W       = 34;
  localparam int QUO_W       = 8;
  localparam int STEP_W      = 3;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = 2;
  localparam int QUEUE_CW    = 3;

  localparam int ADDR_W      = 3;
  localparam int DATA_W      = 32;

  // register index, taken from paddr[2]
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  localparam logic OP_COUNT = 1'b0;
  localparam logic OP_MAP   = 1'b1;

  typedef enum logic {
    KIND_COUNT = 1'b0,
    KIND_MAP   = 1'b1
  } kind_t;

  typedef struct packed {
    kind_t            kind;
    logic [PIX_W-1:0] pixel;
  } item_t;

  typedef struct packed {
    logic [PIX_W-1:0] mapped_pixel;
    logic             lut_ready;
  } result_t;

  function automatic logic [CFG_W-1:0] clamp_side(input logic [CFG_W-1:0] v);
    logic [CFG_W-1:0] r;
    if (v == '0) begin
      r = CFG_W'(1);
    end else if (v > CFG_W'(MAX_SIDE)) begin
      r = CFG_W'(MAX_SIDE);
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

// File: rtl/heq_in_if.sv
// ----------------------------------------------------------------------------
// heq_in_if
// input pixel channel: op and pixel with valid/ready
// ----------------------------------------------------------------------------
interface heq_in_if;
  logic                      valid;
  logic                      ready;
  logic                      op;
  logic [heq_pkg::PIX_W-1:0] pixel;

  modport source (output valid, op, pixel, input ready);
  modport sink   (input valid, op, pixel, output ready);
endinterface

// File: rtl/heq_out_if.sv
// ----------------------------------------------------------------------------
// heq_out_if
// result channel: mapped pixel and table flag with valid/ready
// ----------------------------------------------------------------------------
interface heq_out_if;
  logic                      valid;
  logic                      ready;
  logic [heq_pkg::PIX_W-1:0] mapped_pixel;
  logic                      lut_ready;

  modport source (output valid, mapped_pixel, lut_ready, input ready);
  modport sink   (input valid, mapped_pixel, lut_ready, output ready);
endinterface

// File: rtl/heq_ram.sv
// ----------------------------------------------------------------------------
// heq_ram
// generic one-write one-read ram, registered read, read returns old data
// ----------------------------------------------------------------------------
module heq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/heq_front.sv
// ----------------------------------------------------------------------------
// heq_front
// accepts pixel beats, tags them as count or map work, queues them
// ----------------------------------------------------------------------------
module heq_front (
  input  logic            clk,
  input  logic            rst,
  heq_in_if.sink          in_ch,
  output logic            q_valid,
  output heq_pkg::item_t  q_item,
  input  logic            q_pop
);

  heq_pkg::item_t                   queue [heq_pkg::QUEUE_DEPTH];
  logic [heq_pkg::QUEUE_AW-1:0]     wp;
  logic [heq_pkg::QUEUE_AW-1:0]     rp;
  logic [heq_pkg::QUEUE_CW-1:0]     fill;
  heq_pkg::item_t                   item_in;
  logic                             push;

  always_comb begin
    item_in.pixel = in_ch.pixel;
    unique case (in_ch.op)
      heq_pkg::OP_MAP:   item_in.kind = heq_pkg::KIND_MAP;
      default:           item_in.kind = heq_pkg::KIND_COUNT;
    endcase
  end

  assign in_ch.ready = (fill != heq_pkg::QUEUE_CW'(heq_pkg::QUEUE_DEPTH));
  assign push        = in_ch.valid && in_ch.ready;
  assign q_valid     = (fill != '0);
  assign q_item      = queue[rp];

  always_ff @(posedge clk) begin
    if (push) begin
      queue[wp] <= item_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp   <= '0;
      rp   <= '0;
      fill <= '0;
    end else begin
      if (push) begin
        wp <= wp + 1'b1;
      end
      if (q_pop) begin
        rp <= rp + 1'b1;
      end
      fill <= fill + heq_pkg::QUEUE_CW'(push) - heq_pkg::QUEUE_CW'(q_pop);
    end
  end

endmodule

// File: rtl/heq_back.sv
// ----------------------------------------------------------------------------
// heq_back
// runs queued work: histogram increments, table lookups and the table build
// ----------------------------------------------------------------------------
module heq_back (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [heq_pkg::CNT_W-1:0]  total,
  input  logic                       q_valid,
  input  heq_pkg::item_t             q_item,
  output logic                       q_pop,
  heq_out_if.source                  out_ch
);

  typedef enum logic [7:0] {
    S_RUN   = 8'b0000_0001,
    S_WAIT  = 8'b0000_0010,
    S_READ  = 8'b0000_0100,
    S_ACC   = 8'b0000_1000,
    S_NUM   = 8'b0001_0000,
    S_SAT   = 8'b0010_0000,
    S_DIV   = 8'b0100_0000,
    S_WRITE = 8'b1000_0000
  } state_t;

  state_t state;

  // histogram pipeline
  logic [heq_pkg::HIST_DEPTH-1:0] hist_vld;
  logic                           s1_v;
  logic [heq_pkg::PIX_W-1:0]      s1_addr;
  logic                           lw_v;
  logic [heq_pkg::PIX_W-1:0]      lw_addr;
  logic [heq_pkg::BIN_W-1:0]      lw_data;
  logic [heq_pkg::BIN_W-1:0]      bin_old;
  logic [heq_pkg::BIN_W-1:0]      bin_new;
  logic [heq_pkg::PIX_W-1:0]      h_raddr;
  logic [heq_pkg::BIN_W-1:0]      h_rdata;
  logic [heq_pkg::CNT_W-1:0]      pixels_counted;
  logic [heq_pkg::CNT_W-1:0]      count_inc;
  logic                           trig;

  // table build
  logic                           table_valid;
  logic [heq_pkg::PIX_W-1:0]      idx;
  logic [heq_pkg::CNT_W-1:0]      cdf;
  logic [heq_pkg::NUM_W-1:0]      rem;
  logic [heq_pkg::NUM_W-1:0]      dsh;
  logic [heq_pkg::QUO_W-1:0]      quo;
  logic [heq_pkg::STEP_W-1:0]     step;
  logic                           rem_ge;
  logic [heq_pkg::PIX_W-1:0]      m_wdata;
  logic                           m_we;
  logic [heq_pkg::PIX_W-1:0]      m_rdata;

  // lookups and result buffer
  logic                           lk_v;
  logic                           lk_ok;
  heq_pkg::result_t               obuf [2];
  logic                           owp;
  logic                           orp;
  logic [1:0]                     ocnt;
  logic                           drain;
  logic                           can_map;
  logic                           pop_cnt;
  logic                           pop_map;
  heq_pkg::result_t               push_res;

  // ---------------------------------------------------------------- pop logic
  assign drain   = out_ch.valid && out_ch.ready;
  assign can_map = ({1'b0, ocnt} + {2'b0, lk_v}) < (3'd2 + {2'b0, drain});

  always_comb begin
    q_pop = 1'b0;
    if ((state == S_RUN) && q_valid) begin
      unique case (q_item.kind)
        heq_pkg::KIND_MAP:   q_pop = can_map;
        default:             q_pop = 1'b1;
      endcase
    end
  end

  assign pop_cnt   = q_pop && (q_item.kind == heq_pkg::KIND_COUNT);
  assign pop_map   = q_pop && (q_item.kind == heq_pkg::KIND_MAP);
  assign count_inc = pixels_counted + 1'b1;
  assign trig      = (count_inc >= total);

  // ---------------------------------------------------------------- histogram
  assign h_raddr = (state == S_READ) ? idx : q_item.pixel;

  // the previous write landed on the edge that read this bin, so forward it
  always_comb begin
    if (lw_v && (lw_addr == s1_addr)) begin
      bin_old = lw_data;
    end else if (hist_vld[s1_addr]) begin
      bin_old = h_rdata;
    end else begin
      bin_old = '0;
    end
  end
  assign bin_new = bin_old + 1'b1;

  heq_ram #(
    .WIDTH (heq_pkg::BIN_W),
    .DEPTH (heq_pkg::HIST_DEPTH)
  ) u_hist (
    .clk   (clk),
    .we    (s1_v),
    .waddr (s1_addr),
    .wdata (bin_new),
    .raddr (h_raddr),
    .rdata (h_rdata)
  );

  // ---------------------------------------------------------------- map table
  assign m_we    = (state == S_WRITE);
  assign m_wdata = (idx == '0) ? '0 : quo;
  assign rem_ge  = (rem >= dsh);

  heq_ram #(
    .WIDTH (heq_pkg::PIX_W),
    .DEPTH (heq_pkg::HIST_DEPTH)
  ) u_map (
    .clk   (clk),
    .we    (m_we),
    .waddr (idx),
    .wdata (m_wdata),
    .raddr (q_item.pixel),
    .rdata (m_rdata)
  );

  // ---------------------------------------------------------------- sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_RUN;
      hist_vld       <= '0;
      s1_v           <= 1'b0;
      lw_v           <= 1'b0;
      pixels_counted <= '0;
      table_valid    <= 1'b0;
      idx            <= '0;
      step           <= '0;
    end else begin
      s1_v <= pop_cnt;
      lw_v <= s1_v;
      if (s1_v) begin
        hist_vld[s1_addr] <= 1'b1;
      end
      unique case (state)
        S_RUN: begin
          if (pop_cnt) begin
            pixels_counted <= count_inc;
            if (trig) begin
              state <= S_WAIT;
            end
          end
        end
        S_WAIT: begin
          // last increment is written in this cycle
          idx   <= '0;
          state <= S_READ;
        end
        S_READ: begin
          state <= S_ACC;
        end
        S_ACC: begin
          state <= S_NUM;
        end
        S_NUM: begin
          state <= S_SAT;
        end
        S_SAT: begin
          step <= '0;
          if (rem_ge) begin
            state <= S_WRITE;
          end else begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          step <= step + 1'b1;
          if (step == heq_pkg::STEP_W'(heq_pkg::QUO_W - 1)) begin
            state <= S_WRITE;
          end
        end
        S_WRITE: begin
          if (idx == heq_pkg::PIX_W'(heq_pkg::HIST_DEPTH - 1)) begin
            hist_vld       <= '0;
            pixels_counted <= '0;
            table_valid    <= 1'b1;
            state          <= S_RUN;
          end else begin
            idx   <= idx + 1'b1;
            state <= S_READ;
          end
        end
        default: begin
          state <= S_RUN;
        end
      endcase
    end
  end

  // datapath of the build, no reset needed
  always_ff @(posedge clk) begin
    s1_addr <= q_item.pixel;
    lw_addr <= s1_addr;
    lw_data <= bin_new;
    unique case (state)
      S_WAIT: begin
        cdf <= '0;
      end
      S_ACC: begin
        cdf <= cdf + (hist_vld[idx] ? h_rdata : '0);
      end
      S_NUM: begin
        // 510*cdf + N over a divisor of 2N, first probe at 2N << 8
        rem <= {cdf, 9'b0} - {{(heq_pkg::NUM_W - heq_pkg::CNT_W - 1){1'b0}}, cdf, 1'b0}
             + {{(heq_pkg::NUM_W - heq_pkg::CNT_W){1'b0}}, total};
        dsh <= {total, 1'b0, 8'b0};
      end
      S_SAT: begin
        if (rem_ge) begin
          quo <= '1;
        end else begin
          quo <= '0;
          dsh <= dsh >> 1;
        end
      end
      S_DIV: begin
        if (rem_ge) begin
          rem <= rem - dsh;
        end
        quo <= {quo[heq_pkg::QUO_W-2:0], rem_ge};
        dsh <= dsh >> 1;
      end
      default: begin
      end
    endcase
  end

  // ---------------------------------------------------------------- results
  always_comb begin
    push_res.lut_ready    = lk_ok;
    push_res.mapped_pixel = lk_ok ? m_rdata : '0;
  end

  always_ff @(posedge clk) begin
    lk_ok <= table_valid;
    if (lk_v) begin
      obuf[owp] <= push_res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lk_v <= 1'b0;
      owp  <= 1'b0;
      orp  <= 1'b0;
      ocnt <= '0;
    end else begin
      lk_v <= pop_map;
      if (lk_v) begin
        owp <= ~owp;
      end
      if (drain) begin
        orp <= ~orp;
      end
      ocnt <= ocnt + 2'(lk_v) - 2'(drain);
    end
  end

  assign out_ch.valid        = (ocnt != '0);
  assign out_ch.mapped_pixel = obuf[orp].mapped_pixel;
  assign out_ch.lut_ready    = obuf[orp].lut_ready;

endmodule

// File: rtl/histogram_equalizer_unit.sv
// ----------------------------------------------------------------------------
// histogram_equalizer_unit
// global 8-bit histogram equalization with an apb register port
// ----------------------------------------------------------------------------
// throughput: one pixel beat per cycle, count and map beats mixed freely,
//   while the queue has room; map results leave via a two-entry buffer
// frame end: each bin is read, summed, saturated or divided bit-serially and
//   written to the table; input stalls once the 4-deep queue fills
// reset: synchronous; histogram cleared at once, no table, size 640 x 480
module histogram_equalizer_unit (
  input  logic                         clk,
  input  logic                         rst,
  heq_in_if.sink                       in_ch,
  heq_out_if.source                    out_ch,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [heq_pkg::ADDR_W-1:0]   paddr,
  input  logic [heq_pkg::DATA_W-1:0]   pwdata,
  output logic [heq_pkg::DATA_W-1:0]   prdata,
  output logic                         pready
);

  logic [heq_pkg::CFG_W-1:0]   width_reg;
  logic [heq_pkg::CFG_W-1:0]   height_reg;
  logic [heq_pkg::CFG_W-1:0]   w_eff;
  logic [heq_pkg::CFG_W-1:0]   h_eff;
  logic [2*heq_pkg::CFG_W-1:0] prod;
  logic [heq_pkg::CNT_W-1:0]   total;
  logic                        cfg_wr;
  logic                        q_valid;
  logic                        q_pop;
  heq_pkg::item_t              q_item;

  // ---------------------------------------------------------------- registers
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      width_reg  <= heq_pkg::CFG_W'(heq_pkg::W_RESET);
      height_reg <= heq_pkg::CFG_W'(heq_pkg::H_RESET);
      w_eff      <= heq_pkg::CFG_W'(heq_pkg::W_RESET);
      h_eff      <= heq_pkg::CFG_W'(heq_pkg::H_RESET);
    end else if (cfg_wr) begin
      unique case (paddr[heq_pkg::ADDR_W-1])
        heq_pkg::REG_WIDTH: begin
          width_reg <= pwdata[heq_pkg::CFG_W-1:0];
          w_eff     <= heq_pkg::clamp_side(pwdata[heq_pkg::CFG_W-1:0]);
        end
        default: begin
          height_reg <= pwdata[heq_pkg::CFG_W-1:0];
          h_eff      <= heq_pkg::clamp_side(pwdata[heq_pkg::CFG_W-1:0]);
        end
      endcase
    end
  end

  always_comb begin
    unique case (paddr[heq_pkg::ADDR_W-1])
      heq_pkg::REG_WIDTH:
        prdata = {{(heq_pkg::DATA_W - heq_pkg::CFG_W){1'b0}}, width_reg};
      default:
        prdata = {{(heq_pkg::DATA_W - heq_pkg::CFG_W){1'b0}}, height_reg};
    endcase
  end

  // pixels per frame, at most 4096 * 4096
  assign prod  = w_eff * h_eff;
  assign total = prod[heq_pkg::CNT_W-1:0];

  // ---------------------------------------------------------------- datapath
  heq_front u_front (
    .clk     (clk),
    .rst     (rst),
    .in_ch   (in_ch),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_pop   (q_pop)
  );

  heq_back u_back (
    .clk     (clk),
    .rst     (rst),
    .total   (total),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

`ifndef SYNTH
  a_pop_needs_item: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid)
    else $error("back popped an empty queue");

  a_no_table_zero: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && !out_ch.lut_ready) |-> (out_ch.mapped_pixel == '0))
    else $error("result without a table is not zero");

  a_width_write: assert property (@(posedge clk) disable iff (rst)
    (cfg_wr && (paddr[heq_pkg::ADDR_W-1] == heq_pkg::REG_WIDTH))
      |=> (width_reg == $past(pwdata[heq_pkg::CFG_W-1:0])))
    else $error("width register write lost");

  a_eff_width: assert property (@(posedge clk) disable iff (rst)
    $past(cfg_wr) |-> ((w_eff != '0) && (w_eff <= heq_pkg::CFG_W'(heq_pkg::MAX_SIDE))))
    else $error("clamped width out of range");
`endif

endmodule
